// File: design/dt2i_pkg.sv
// Shared character codes, widths and scan phase type for the decimal text converter.
package dt2i_pkg;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int RES_W  = 128;
  localparam int HALF_W = 64;

  // BCD digit correction after each right shift.
  localparam logic [3:0] DIGIT_LIMIT = 4'd7;
  localparam logic [3:0] DIGIT_ADJ   = 4'd3;

  typedef enum logic [1:0] {
    PH_BLANK  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_IGNORE = 2'd2
  } phase_t;

endpackage

// File: design/decimal_text_to_int128_top.sv
// Top level of the decimal text to signed 128-bit integer converter.
//
// Usage: the string arrives one byte per transfer on the input channel
// (char_code, last, in_valid, in_stall). Leading spaces, tabs, newlines and
// plus signs are skipped, one optional minus sign is taken, then decimal
// digits up to the first non-digit; anything after that is ignored.
// Ordinary bytes are taken one per cycle while in_stall is low. The byte
// marked last starts the conversion, which shifts the stored BCD digits
// right one bit per cycle (reverse double dabble) and collects the binary
// value one bit per cycle, negating it serially on the fly when the string
// was negative. The number of conversion steps grows with the number of
// stored digits and never falls below the result width. After the final
// step the result waits in the hold state and is loaded into the output
// register once that register is free. in_stall is high from the last
// byte until the result has been loaded into the output register.
// The output channel (value_low, value_high, overflow, out_valid, out_stall)
// holds a result until it is taken; while out_stall is high the next string
// may still be received and converted, but its result waits for the
// output register to become free. A synchronous reset returns the scanner to
// the blank phase, clears the digit store and drops any pending result.
module decimal_text_to_int128_top
  import dt2i_pkg::*;
#(
  parameter int MAX_DIGITS = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        char_code,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HALF_W-1:0] value_low,
  output logic [HALF_W-1:0] value_high,
  output logic              overflow
);

  localparam int BCD_W   = 4 * MAX_DIGITS;
  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int STEPS   = (4 * MAX_DIGITS > RES_W) ? 4 * MAX_DIGITS : RES_W;
  localparam int STEP_W  = $clog2(STEPS);
  localparam int FOUR_W  = CNT_W + 2;
  localparam int WIDE_W  = (FOUR_W > STEP_W + 1) ? FOUR_W : STEP_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_HOLD
  } state_t;

  state_t             state;
  phase_t             phase;
  logic               negative;
  logic [CNT_W-1:0]   digit_count;
  logic               too_many;
  logic [BCD_W-1:0]   bcd;
  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_end;
  logic               conv_neg;
  logic               conv_over;
  logic               seen_one;
  logic [RES_W-1:0]   res;

  // Scanner next values for the byte on the input.
  phase_t             phase_next;
  logic               negative_next;
  logic [CNT_W-1:0]   digit_count_next;
  logic               too_many_next;
  logic [BCD_W-1:0]   bcd_next;
  logic               is_digit;
  logic [3:0]         digit;
  logic               take;
  logic               in_acc;

  // Conversion datapath.
  logic [BCD_W-1:0]   bcd_shift;
  logic [BCD_W-1:0]   bcd_step;
  logic               lsb;
  logic               res_bit;
  logic               in_window;
  logic [WIDE_W-1:0]  four_n;
  logic [WIDE_W-1:0]  end_wide;
  logic               out_free;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign digit    = 4'(char_code - CHAR_ZERO);

  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    digit_count_next = digit_count;
    too_many_next    = too_many;
    bcd_next         = bcd;
    take             = 1'b0;
    case (phase)
      PH_BLANK: begin
        if (char_code == CHAR_SPACE || char_code == CHAR_TAB ||
            char_code == CHAR_NL || char_code == CHAR_PLUS) begin
          phase_next = PH_BLANK;
        end else if (char_code == CHAR_MINUS) begin
          negative_next = 1'b1;
          phase_next    = PH_DIGITS;
        end else if (is_digit) begin
          take       = 1'b1;
          phase_next = PH_DIGITS;
        end else begin
          phase_next = PH_IGNORE;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          take = 1'b1;
        end else begin
          phase_next = PH_IGNORE;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
    // Leading zeros are not stored; digits beyond capacity only set the flag.
    if (take && !(digit_count == '0 && digit == 4'd0)) begin
      if (digit_count < CNT_W'(MAX_DIGITS)) begin
        bcd_next         = (bcd << 4) | BCD_W'(digit);
        digit_count_next = digit_count + 1'b1;
      end else begin
        too_many_next = 1'b1;
      end
    end
  end

  // One reverse double dabble step: shift right, then pull every digit
  // above seven back by three.
  assign lsb       = bcd[0];
  assign bcd_shift = bcd >> 1;

  always_comb begin
    bcd_step = bcd_shift;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_shift[4*i +: 4] > DIGIT_LIMIT) begin
        bcd_step[4*i +: 4] = bcd_shift[4*i +: 4] - DIGIT_ADJ;
      end
    end
  end

  // Serial two's complement: bits pass unchanged up to and including the
  // first one, and are inverted after it.
  assign res_bit   = lsb ^ (conv_neg & seen_one);
  assign in_window = ({1'b0, step} < (STEP_W + 1)'(RES_W));

  // Index of the final conversion step: the larger of RES_W and 4 * n, less one.
  assign four_n   = WIDE_W'({digit_count_next, 2'b00});
  assign end_wide = ((four_n > WIDE_W'(RES_W)) ? four_n : WIDE_W'(RES_W)) - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_BLANK;
      negative    <= 1'b0;
      digit_count <= '0;
      too_many    <= 1'b0;
      bcd         <= '0;
      out_valid   <= 1'b0;
      step        <= '0;
    end else begin
      // A waiting result refills the output register in the cycle that the
      // previous one leaves it, so only clear it when nothing is waiting.
      if (out_valid && !out_stall && state != S_HOLD) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            bcd <= bcd_next;
            if (last) begin
              // The scanner returns to its reset state; the conversion keeps
              // what it needs in its own registers.
              phase       <= PH_BLANK;
              negative    <= 1'b0;
              digit_count <= '0;
              too_many    <= 1'b0;
              conv_neg    <= negative_next;
              conv_over   <= too_many_next;
              seen_one    <= 1'b0;
              step        <= '0;
              step_end    <= STEP_W'(end_wide);
              state       <= S_CONV;
            end else begin
              phase       <= phase_next;
              negative    <= negative_next;
              digit_count <= digit_count_next;
              too_many    <= too_many_next;
            end
          end
        end
        S_CONV: begin
          bcd  <= bcd_step;
          step <= step + 1'b1;
          if (in_window) begin
            res      <= {res_bit, res[RES_W-1:1]};
            seen_one <= seen_one | lsb;
          end else if (lsb) begin
            conv_over <= 1'b1;
          end
          if (step == step_end) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            value_low  <= res[HALF_W-1:0];
            value_high <= res[RES_W-1:HALF_W];
            overflow   <= conv_over;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_last_starts_conv: assert property (@(posedge clk) disable iff (rst)
    in_acc && last |=> state == S_CONV)
    else $error("last byte did not start a conversion");

  a_conv_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_CONV && step == step_end |=> state == S_HOLD)
    else $error("conversion did not stop at its final step");

  a_hold_loads: assert property (@(posedge clk) disable iff (rst)
    state == S_HOLD && out_free |=> out_valid && state == S_IDLE)
    else $error("finished result was not loaded into the output register");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond capacity");

  a_bcd_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_HOLD |-> bcd == '0)
    else $error("digit store not empty after conversion");

endmodule
